[rtl/csem_pkg.sv]
// Shared types and constants of the counting semaphore table.
`default_nettype none
package csem_pkg;

  localparam int SLOT_IDX_W = 3;
  localparam int ID_W       = 4;
  localparam int INIT_W     = 16;

  localparam int DEF_NUM_SEMAPHORES = 8;
  localparam int DEF_NUM_REQUESTERS = 16;
  localparam int DEF_COUNT_BITS     = 16;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_WAIT   = 2'd1;
  localparam logic [1:0] MODE_POST   = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic [SLOT_IDX_W-1:0]   sem_index;
    logic signed [INIT_W-1:0] init_value;
    logic [ID_W-1:0]         requester_id;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic [SLOT_IDX_W-1:0] assigned_index;
    logic                  must_block;
    logic                  woken_valid;
    logic [ID_W-1:0]       woken_id;
  } out_item_t;

  // Write commands from the slot table to the shared waiter links.
  typedef struct packed {
    logic            append_en;
    logic [ID_W-1:0] tail_ptr;
    logic            clear_en;
    logic [ID_W-1:0] req_ptr;
    logic            pop_en;
    logic [ID_W-1:0] pop_ptr;
  } link_cmd_t;

endpackage
`default_nettype wire

[rtl/csem_wait_links.sv]
// Shared next-link store of the waiter queues, one entry per requester.
`default_nettype none
module csem_wait_links #(
  parameter int NUM_REQUESTERS = csem_pkg::DEF_NUM_REQUESTERS
) (
  input  wire logic                  clk,
  input  wire logic [csem_pkg::ID_W-1:0] rd_ptr,
  output logic [csem_pkg::ID_W-1:0]  rd_next,
  output logic                       rd_has_next,
  input  wire csem_pkg::link_cmd_t   cmd
);
  import csem_pkg::*;

  localparam int LINK_AW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;

  logic [ID_W-1:0] next_r     [NUM_REQUESTERS];
  logic            has_next_r [NUM_REQUESTERS];

  logic [LINK_AW-1:0] rd_idx, tail_idx, req_idx, pop_idx;
  logic               rd_ok, tail_ok, req_ok, pop_ok;

  always_comb begin
    rd_idx   = LINK_AW'(rd_ptr);
    tail_idx = LINK_AW'(cmd.tail_ptr);
    req_idx  = LINK_AW'(cmd.req_ptr);
    pop_idx  = LINK_AW'(cmd.pop_ptr);
    rd_ok    = int'(rd_ptr) < NUM_REQUESTERS;
    tail_ok  = int'(cmd.tail_ptr) < NUM_REQUESTERS;
    req_ok   = int'(cmd.req_ptr) < NUM_REQUESTERS;
    pop_ok   = int'(cmd.pop_ptr) < NUM_REQUESTERS;
  end

  always_comb begin
    rd_next     = rd_ok ? next_r[rd_idx] : '0;
    rd_has_next = rd_ok && has_next_r[rd_idx];
  end

  // Link the old tail first; the requester's own entry is written last and wins.
  always_ff @(posedge clk) begin
    if (cmd.append_en && tail_ok) begin
      next_r[tail_idx]     <= cmd.req_ptr;
      has_next_r[tail_idx] <= 1'b1;
    end
    if (cmd.pop_en && pop_ok) begin
      has_next_r[pop_idx] <= 1'b0;
    end
    if (cmd.clear_en && req_ok) begin
      next_r[req_idx]     <= '0;
      has_next_r[req_idx] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/csem_slot_table.sv]
// Semaphore slot state and the per-operation read-modify-write logic.
`default_nettype none
module csem_slot_table #(
  parameter int NUM_SEMAPHORES = csem_pkg::DEF_NUM_SEMAPHORES,
  parameter int NUM_REQUESTERS = csem_pkg::DEF_NUM_REQUESTERS,
  parameter int COUNT_BITS     = csem_pkg::DEF_COUNT_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      item_valid,
  input  wire csem_pkg::in_item_t        item,
  output logic [csem_pkg::ID_W-1:0]      link_rd_ptr,
  input  wire logic [csem_pkg::ID_W-1:0] link_rd_next,
  input  wire logic                      link_rd_has_next,
  output csem_pkg::link_cmd_t            link_cmd,
  output csem_pkg::out_item_t            result
);
  import csem_pkg::*;

  localparam int SLOT_AW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam longint CNT_MAX_L = (longint'(1) <<< (COUNT_BITS - 1)) - 1;
  localparam logic signed [32:0] SAT_MAX = 33'(CNT_MAX_L);
  localparam logic signed [32:0] SAT_MIN = 33'(-CNT_MAX_L - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};

  logic                  used_r     [NUM_SEMAPHORES];
  logic                  used_nxt   [NUM_SEMAPHORES];
  logic [COUNT_BITS-1:0] count_r    [NUM_SEMAPHORES];
  logic [COUNT_BITS-1:0] count_nxt  [NUM_SEMAPHORES];
  logic                  nonempty_r   [NUM_SEMAPHORES];
  logic                  nonempty_nxt [NUM_SEMAPHORES];
  logic [ID_W-1:0]       head_r     [NUM_SEMAPHORES];
  logic [ID_W-1:0]       head_nxt   [NUM_SEMAPHORES];
  logic [ID_W-1:0]       tail_r     [NUM_SEMAPHORES];
  logic [ID_W-1:0]       tail_nxt   [NUM_SEMAPHORES];

  logic                  free_found;
  logic [SLOT_AW-1:0]    free_slot;
  logic [SLOT_AW-1:0]    sidx;
  logic                  slot_ok;
  logic                  req_ok;
  logic signed [32:0]    init_ext;
  logic signed [32:0]    init_sat;
  logic [COUNT_BITS-1:0] cur_cnt;

  // Lowest unused slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = NUM_SEMAPHORES - 1; s >= 0; s--) begin
      if (!used_r[s]) begin
        free_found = 1'b1;
        free_slot  = SLOT_AW'(s);
      end
    end
  end

  always_comb begin
    sidx     = SLOT_AW'(item.sem_index);
    slot_ok  = (int'(item.sem_index) < NUM_SEMAPHORES) && used_r[sidx];
    req_ok   = int'(item.requester_id) < NUM_REQUESTERS;
    cur_cnt  = count_r[sidx];
    init_ext = 33'($signed(item.init_value));
    if (init_ext > SAT_MAX) begin
      init_sat = SAT_MAX;
    end else if (init_ext < SAT_MIN) begin
      init_sat = SAT_MIN;
    end else begin
      init_sat = init_ext;
    end
    link_rd_ptr = head_r[sidx];
  end

  always_comb begin
    used_nxt     = used_r;
    count_nxt    = count_r;
    nonempty_nxt = nonempty_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    link_cmd     = '0;
    result       = '0;
    result.status = 1'b1;
    if (item_valid) begin
      case (item.mode)
        MODE_CREATE: begin
          if (free_found) begin
            used_nxt[free_slot]     = 1'b1;
            count_nxt[free_slot]    = COUNT_BITS'(init_sat);
            nonempty_nxt[free_slot] = 1'b0;
            head_nxt[free_slot]     = '0;
            tail_nxt[free_slot]     = '0;
            result.status           = 1'b0;
            result.assigned_index   = SLOT_IDX_W'(free_slot);
          end
        end
        MODE_WAIT: begin
          if (slot_ok) begin
            if (!cur_cnt[COUNT_BITS-1] && (cur_cnt != '0)) begin
              count_nxt[sidx] = cur_cnt - COUNT_BITS'(1);
              result.status   = 1'b0;
            end else if (req_ok) begin
              if (!nonempty_r[sidx]) begin
                head_nxt[sidx]     = item.requester_id;
                nonempty_nxt[sidx] = 1'b1;
              end else begin
                link_cmd.append_en = 1'b1;
                link_cmd.tail_ptr  = tail_r[sidx];
              end
              tail_nxt[sidx]    = item.requester_id;
              link_cmd.clear_en = 1'b1;
              link_cmd.req_ptr  = item.requester_id;
              result.status     = 1'b0;
              result.must_block = 1'b1;
            end
          end
        end
        MODE_POST: begin
          if (slot_ok) begin
            result.status = 1'b0;
            if (nonempty_r[sidx]) begin
              result.woken_valid = 1'b1;
              result.woken_id    = head_r[sidx];
              if (link_rd_has_next) begin
                head_nxt[sidx]   = link_rd_next;
                link_cmd.pop_en  = 1'b1;
                link_cmd.pop_ptr = head_r[sidx];
              end else begin
                nonempty_nxt[sidx] = 1'b0;
              end
            end else if (cur_cnt != CNT_MAX) begin
              count_nxt[sidx] = cur_cnt + COUNT_BITS'(1);
            end
          end
        end
        default: begin
          result.status = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SEMAPHORES; s++) begin
        used_r[s]     <= 1'b0;
        count_r[s]    <= '0;
        nonempty_r[s] <= 1'b0;
        head_r[s]     <= '0;
        tail_r[s]     <= '0;
      end
    end else begin
      used_r     <= used_nxt;
      count_r    <= count_nxt;
      nonempty_r <= nonempty_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/counting_semaphore_table_unit.sv]
// Top level of the counting semaphore table: input register, slot table, links, result register.
`default_nettype none
// Usage:
//   Command channel: drive in_data and raise start; the transfer happens at a
//   rising edge where start is high and busy is low. busy is high only while
//   rst_n is low and until the first edge at which rst_n is high, so one
//   command may be issued in every cycle from then on.
//   Each command gives exactly one result. out_valid is high for one cycle
//   with out_data; the result transfers at the edge that ends that cycle.
//   The receiver cannot stall the block, so there is no back pressure.
//   Path: a command taken into the input register is handled by the slot
//   table, and its result is captured in the result register.
//   Throughput: one command per cycle. Each command is a single
//   read-modify-write of the slot registers and the waiter links, done
//   between the input register and the result register, so the next command
//   sees the updated table without any hazard.
//   Reset (synchronous, active low) frees all slots, zeroes all counts and
//   empties all queues at once. The waiter links are not cleared: an entry is
//   written when its requester is queued, before it can be followed.
module counting_semaphore_table_unit #(
  parameter int NUM_SEMAPHORES = csem_pkg::DEF_NUM_SEMAPHORES,
  parameter int NUM_REQUESTERS = csem_pkg::DEF_NUM_REQUESTERS,
  parameter int COUNT_BITS     = csem_pkg::DEF_COUNT_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire csem_pkg::in_item_t in_data,
  output logic                    out_valid,
  output csem_pkg::out_item_t     out_data
);
  import csem_pkg::*;

  logic      busy_r;
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  link_cmd_t link_cmd;
  logic [ID_W-1:0] link_rd_ptr;
  logic [ID_W-1:0] link_rd_next;
  logic            link_rd_has_next;
  logic            accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Hold off commands during reset and until the first edge with rst_n high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
    end
  end

  // Capture the command on transfer; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
    out_item_r <= result;
  end

  csem_slot_table #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .NUM_REQUESTERS (NUM_REQUESTERS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_slots (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (in_valid_r),
    .item             (in_item_r),
    .link_rd_ptr      (link_rd_ptr),
    .link_rd_next     (link_rd_next),
    .link_rd_has_next (link_rd_has_next),
    .link_cmd         (link_cmd),
    .result           (result)
  );

  csem_wait_links #(
    .NUM_REQUESTERS (NUM_REQUESTERS)
  ) u_links (
    .clk         (clk),
    .rd_ptr      (link_rd_ptr),
    .rd_next     (link_rd_next),
    .rd_has_next (link_rd_has_next),
    .cmd         (link_cmd)
  );

endmodule
`default_nettype wire

[rtl/csem_checker.sv]
// Port-level checker of the counting semaphore table and its bind.
`default_nettype none
module csem_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire csem_pkg::out_item_t out_data
);
  import csem_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // Every transfer gives a result through the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("result missing after command transfer");

  // No result without an earlier command transfer.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without a command");

  // An error result carries nothing else.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |->
      (out_data.assigned_index == '0 && !out_data.must_block &&
       !out_data.woken_valid && out_data.woken_id == '0))
    else $error("error result with nonzero fields");

  // A result never both blocks and wakes, and an idle wake id is zero.
  a_block_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_data.must_block && out_data.woken_valid) &&
                   (out_data.woken_valid || out_data.woken_id == '0)))
    else $error("inconsistent block and wake fields");

endmodule

bind counting_semaphore_table_unit csem_checker u_csem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
